>>> rtl/core/ssq_pkg.sv
package ssq_pkg;

	localparam int unsigned TIME_BITS   = 64;
	localparam int unsigned DUR_BITS    = 32;
	localparam int unsigned PORT_ID_BITS = 8;
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned REL_CNT_BITS = $clog2(MAX_RESULTS);

	typedef logic [TIME_BITS-1:0] time_val_t;

	typedef enum logic [1:0] {
		ST_TICK_RESULT = 2'd0,
		ST_SLEEP_OK    = 2'd1,
		ST_SLEEP_NONPOS = 2'd2,
		ST_QUEUE_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_SLEEP = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_EXEC = 2'b10
	} fsm_t;

	// row-wide command to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

>>> rtl/core/ssq_cell.sv
module ssq_cell #(
	parameter int unsigned ID_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssq_pkg::cell_ctl_t    ctl,
	input  ssq_pkg::time_val_t    new_wake,
	input  logic [ID_BITS-1:0]    new_id,
	input  ssq_pkg::time_val_t    tick,
	input  logic                  prev_valid,
	input  logic                  prev_gt,
	input  ssq_pkg::time_val_t    prev_wake,
	input  logic [ID_BITS-1:0]    prev_id,
	input  logic                  next_valid,
	input  ssq_pkg::time_val_t    next_wake,
	input  logic [ID_BITS-1:0]    next_id,
	output logic                  valid,
	output logic                  gt,
	output logic                  due,
	output ssq_pkg::time_val_t    wake,
	output logic [ID_BITS-1:0]    id
);

	logic               valid_q;
	ssq_pkg::time_val_t wake_q;
	logic [ID_BITS-1:0] id_q;

	// gt marks cells that sit behind the new entry; equal times stay ahead (FIFO)
	assign gt    = valid_q && (wake_q > new_wake);
	assign due   = valid_q && (wake_q <= tick);
	assign valid = valid_q;
	assign wake  = wake_q;
	assign id    = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (ctl.ins && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			wake_q <= next_wake;
			id_q   <= next_id;
		end else if (ctl.ins) begin
			if (prev_gt) begin
				// shift right: the entry ahead moves in
				if (gt || !valid_q) begin
					wake_q <= prev_wake;
					id_q   <= prev_id;
				end
			end else if (gt || (!valid_q && prev_valid)) begin
				wake_q <= new_wake;
				id_q   <= new_id;
			end
		end
	end

endmodule

>>> rtl/core/sorted_sleep_wakeup_queue_unit.sv
// Sorted sleep/wakeup queue. A 64-bit tick counter and a row of QUEUE_DEPTH
// cells hold sleepers ordered by wake time, equal times in arrival order.
// s_tuser[0] is the opcode (0 tick, 1 sleep); s_tdata carries thread id and
// signed duration. A sleep request first takes the transfer and forms the
// saturated wake time, then every cell compares in parallel and the row
// opens a slot in place unless the duration is <= 0 or the row is full. A
// tick releases the n due entries, at most 16, and gives one result even if
// none are due; while the output is free the front cell leaves once a cycle
// as the row shifts left. Each result goes through a single output register.
module sorted_sleep_wakeup_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] thread_id, [39:8] duration
	input  logic [39:0] s_tdata,
	// [0] opcode
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] woken_id, [71:8] now
	output logic [71:0] m_tdata,
	// [0] woken_valid, [2:1] status
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	localparam int unsigned PID = ssq_pkg::PORT_ID_BITS;

	ssq_pkg::fsm_t      state_q;
	ssq_pkg::time_val_t tick_q;
	ssq_pkg::opcode_t   op_q;
	logic [ID_BITS-1:0] id_q;
	logic               nonpos_q;
	ssq_pkg::time_val_t wake_q;
	logic [ssq_pkg::REL_CNT_BITS-1:0] rel_cnt_q;

	logic                     out_valid_q;
	logic                     out_woken_q;
	logic [PID-1:0]           out_id_q;
	ssq_pkg::status_t         out_status_q;
	ssq_pkg::time_val_t       out_now_q;
	logic                     out_last_q;

	logic                    cell_valid [QUEUE_DEPTH];
	logic                    cell_gt    [QUEUE_DEPTH];
	logic                    cell_due   [QUEUE_DEPTH];
	ssq_pkg::time_val_t      cell_wake  [QUEUE_DEPTH];
	logic [ID_BITS-1:0]      cell_id    [QUEUE_DEPTH];

	ssq_pkg::cell_ctl_t ctl;
	logic               in_xfer;
	logic               out_free;
	logic               emit;
	logic               emit_woken;
	logic [PID-1:0]     emit_id;
	ssq_pkg::status_t   emit_status;
	logic               emit_last;

	logic [ID_BITS+PID-1:0] in_id_ext;
	logic [ID_BITS+PID-1:0] out_id_ext;
	logic [ssq_pkg::DUR_BITS-1:0] in_dur;
	logic [ssq_pkg::TIME_BITS:0]  wake_sum;

	assign s_tready = (state_q == ssq_pkg::FSM_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign in_dur     = s_tdata[39:8];
	assign in_id_ext  = {{ID_BITS{1'b0}}, s_tdata[7:0]};
	assign out_id_ext = {{PID{1'b0}}, cell_id[0]};
	assign wake_sum   = {1'b0, tick_q} + {{(ssq_pkg::TIME_BITS + 1 - ssq_pkg::DUR_BITS){1'b0}},
		in_dur};

	always_comb begin
		ctl         = '0;
		emit        = 1'b0;
		emit_woken  = 1'b0;
		emit_id     = '0;
		emit_status = ssq_pkg::ST_TICK_RESULT;
		emit_last   = 1'b1;
		if (state_q == ssq_pkg::FSM_EXEC && out_free) begin
			emit = 1'b1;
			if (op_q == ssq_pkg::OP_SLEEP) begin
				priority if (nonpos_q) begin
					emit_status = ssq_pkg::ST_SLEEP_NONPOS;
				end else if (cell_valid[QUEUE_DEPTH-1]) begin
					emit_status = ssq_pkg::ST_QUEUE_FULL;
				end else begin
					emit_status = ssq_pkg::ST_SLEEP_OK;
					ctl.ins     = 1'b1;
				end
			end else if (cell_due[0]) begin
				ctl.pop    = 1'b1;
				emit_woken = 1'b1;
				emit_id    = out_id_ext[PID-1:0];
				emit_last  = !cell_due[1] ||
					(rel_cnt_q == ssq_pkg::REL_CNT_BITS'(ssq_pkg::MAX_RESULTS - 1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ssq_pkg::FSM_IDLE;
			tick_q    <= '0;
			rel_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ssq_pkg::FSM_IDLE: begin
					if (in_xfer) begin
						state_q   <= ssq_pkg::FSM_EXEC;
						rel_cnt_q <= '0;
						if (s_tuser[0] == ssq_pkg::OP_TICK) begin
							tick_q <= tick_q + 1'b1;
						end
					end
				end
				ssq_pkg::FSM_EXEC: begin
					if (emit) begin
						rel_cnt_q <= rel_cnt_q + 1'b1;
						if (emit_last) begin
							state_q <= ssq_pkg::FSM_IDLE;
						end
					end
				end
				default: state_q <= ssq_pkg::FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= ssq_pkg::opcode_t'(s_tuser[0]);
			id_q     <= in_id_ext[ID_BITS-1:0];
			nonpos_q <= (in_dur == '0) || in_dur[ssq_pkg::DUR_BITS-1];
			// saturate on wrap past 2^64-1
			wake_q   <= wake_sum[ssq_pkg::TIME_BITS] ? '1 : wake_sum[ssq_pkg::TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_woken_q  <= emit_woken;
			out_id_q     <= emit_id;
			out_status_q <= emit_status;
			out_now_q    <= tick_q;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_now_q, out_id_q};
	assign m_tuser  = {out_status_q, out_woken_q};
	assign m_tlast  = out_last_q;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic               p_valid;
		logic               p_gt;
		ssq_pkg::time_val_t p_wake;
		logic [ID_BITS-1:0] p_id;
		logic               n_valid;
		ssq_pkg::time_val_t n_wake;
		logic [ID_BITS-1:0] n_id;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_gt    = 1'b0;
			assign p_wake  = '0;
			assign p_id    = '0;
		end else begin : g_body
			assign p_valid = cell_valid[i-1];
			assign p_gt    = cell_gt[i-1];
			assign p_wake  = cell_wake[i-1];
			assign p_id    = cell_id[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_wake  = '0;
			assign n_id    = '0;
		end else begin : g_link
			assign n_valid = cell_valid[i+1];
			assign n_wake  = cell_wake[i+1];
			assign n_id    = cell_id[i+1];
		end

		ssq_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_wake  (wake_q),
			.new_id    (id_q),
			.tick      (tick_q),
			.prev_valid(p_valid),
			.prev_gt   (p_gt),
			.prev_wake (p_wake),
			.prev_id   (p_id),
			.next_valid(n_valid),
			.next_wake (n_wake),
			.next_id   (n_id),
			.valid     (cell_valid[i]),
			.gt        (cell_gt[i]),
			.due       (cell_due[i]),
			.wake      (cell_wake[i]),
			.id        (cell_id[i])
		);
	end

endmodule

>>> sim/ssq_result_check.sv
module ssq_result_check
	import ssq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [7:0] thread_id, [39:8] duration
	input  logic [39:0] s_tdata,
	// [0] opcode
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] woken_id, [71:8] now
	input  logic [71:0] m_tdata,
	// [0] woken_valid, [2:1] status
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          results_due
);

	typedef struct packed {
		logic        woken;
		logic [7:0]  id;
		status_t     status;
		time_val_t   now;
		logic        last;
	} wake_result_t;

	wake_result_t wakeup_q[$];

	// shadow of the sleeper row
	time_val_t   tick_count;
	time_val_t   wake_at [QUEUE_DEPTH];
	logic [7:0]  sleeper [QUEUE_DEPTH];
	int          occupancy;

	task automatic predict_wakeups(input opcode_t op, input logic [7:0] tid,
			input logic signed [31:0] dur);
		wake_result_t r;
		logic [64:0]  sum;
		time_val_t    wake;
		int           pos;
		int           n;
		int           i;
		r.woken  = 1'b0;
		r.id     = '0;
		r.now    = tick_count;
		r.last   = 1'b1;
		r.status = ST_TICK_RESULT;
		if (op == OP_SLEEP) begin
			if (dur <= 0) begin
				r.status = ST_SLEEP_NONPOS;
			end else if (occupancy >= QUEUE_DEPTH) begin
				r.status = ST_QUEUE_FULL;
			end else begin
				sum  = {1'b0, tick_count} + {33'd0, dur};
				wake = sum[64] ? '1 : sum[63:0];
				// equal wake times go behind the ones already queued
				pos = 0;
				while (pos < occupancy && wake_at[pos] <= wake)
					pos++;
				for (i = occupancy; i > pos; i--) begin
					wake_at[i] = wake_at[i-1];
					sleeper[i] = sleeper[i-1];
				end
				wake_at[pos] = wake;
				sleeper[pos] = tid;
				occupancy++;
				r.status = ST_SLEEP_OK;
			end
			wakeup_q.push_back(r);
		end else begin
			tick_count = tick_count + 1;
			r.now = tick_count;
			n = 0;
			while (n < MAX_RESULTS && n < occupancy && wake_at[n] <= tick_count)
				n++;
			if (n == 0) begin
				wakeup_q.push_back(r);
			end else begin
				for (i = 0; i < n; i++) begin
					r.woken = 1'b1;
					r.id    = sleeper[i];
					r.last  = (i == n - 1);
					wakeup_q.push_back(r);
				end
				for (i = n; i < occupancy; i++) begin
					wake_at[i-n] = wake_at[i];
					sleeper[i-n] = sleeper[i];
				end
				occupancy -= n;
			end
		end
	endtask

	always @(posedge clk) begin
		wake_result_t got;
		wake_result_t exp;
		if (!arst_n) begin
			tick_count  = '0;
			occupancy   = 0;
			fail_count  = 0;
			results_due = 0;
			wakeup_q.delete();
		end else begin
			// results first: a result at this edge never belongs to the input taken here
			if (m_tvalid && m_tready) begin
				got.woken  = m_tuser[0];
				got.id     = m_tdata[7:0];
				got.status = status_t'(m_tuser[2:1]);
				got.now    = m_tdata[71:8];
				got.last   = m_tlast;
				if (wakeup_q.size() == 0) begin
					$display("%0t unexpected result: woken=%0b id=%0d status=%0d now=%0d last=%0b",
						$time, got.woken, got.id, got.status, got.now, got.last);
					fail_count++;
				end else begin
					exp = wakeup_q.pop_front();
					if (got !== exp) begin
						$display("%0t mismatch: expected woken=%0b id=%0d status=%0d now=%0d last=%0b",
							$time, exp.woken, exp.id, exp.status, exp.now, exp.last);
						$display("%0t           actual   woken=%0b id=%0d status=%0d now=%0d last=%0b",
							$time, got.woken, got.id, got.status, got.now, got.last);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_wakeups(opcode_t'(s_tuser[0]), s_tdata[7:0], s_tdata[39:8]);
			results_due = wakeup_q.size();
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	import ssq_pkg::*;

	localparam int WATCHDOG   = 5000;
	localparam int HOLD_OFF   = 400;
	localparam int DRAIN_WAIT = 40;
	localparam int PHASE_ITEMS = 100;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int results_due;
	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int items_sent     = 0;
	int quiet_cycles   = 0;
	bit hold_req       = 1'b0;

	always #5 clk = ~clk;

	sorted_sleep_wakeup_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ssq_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	// one request per call; leaves tvalid high so back-to-back transfers stay gapless
	task automatic offer(input opcode_t op, input logic [7:0] tid, input logic [31:0] dur);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {dur, tid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] short_sleep();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 32'd0;
		if (r == 1)
			return 32'd0 - $urandom_range(1, 5);
		return $urandom_range(1, 12);
	endfunction

	task automatic random_burst();
		int k;
		int t;
		if ($urandom_range(9) != 0) begin
			// sleepers, then enough ticks to wake some of them
			k = $urandom_range(1, ($urandom_range(4) == 0) ? 16 : 6);
			repeat (k) offer(OP_SLEEP, 8'($urandom), short_sleep());
			t = $urandom_range(1, 10);
			repeat (t) offer(OP_TICK, 8'($urandom), $urandom);
		end else begin
			repeat ($urandom_range(1, 4))
				offer(opcode_t'($urandom_range(1)), 8'($urandom),
					($urandom_range(3) == 0) ? $urandom : short_sleep());
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int start;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue tick, then ignored durations
		offer(OP_TICK, 8'h00, 32'h0000_0000);
		offer(OP_SLEEP, 8'h12, 32'h0000_0000);
		offer(OP_SLEEP, 8'h34, 32'hFFFF_FFFF);
		offer(OP_SLEEP, 8'h56, 32'h8000_0000);
		// longest sleep parks an entry for the whole run
		offer(OP_SLEEP, 8'hFF, 32'h7FFF_FFFF);
		// same wake time keeps arrival order
		offer(OP_SLEEP, 8'h00, 32'h0000_0001);
		offer(OP_SLEEP, 8'h01, 32'h0000_0001);
		offer(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
		// fill the row, overflow it, then release everything due at once
		for (int i = 0; i < 15; i++)
			offer(OP_SLEEP, 8'(8'h80 + i), 32'd3);
		offer(OP_SLEEP, 8'hAA, 32'd1);
		repeat (3) offer(OP_TICK, 8'($urandom), $urandom);
		drain();

		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = (mode == 1) ? 71 : (mode == 3) ? 24 : 0;
			stall_pct     = (mode == 2) ? 71 : (mode == 3) ? 24 : 0;
			start = items_sent;
			if (mode == 0) begin
				// output held off while requests keep coming: input must back up
				hold_req = 1'b1;
				while (items_sent - start < 30)
					random_burst();
			end
			while (items_sent - start < PHASE_ITEMS)
				random_burst();
			drain();
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
